/* hw/rtl/rciaf_pkg.sv */
// ----------------------------------------------------------------------------
// rciaf_pkg
// Shared types, constants and helpers for the RC input arming/failsafe unit.
// ----------------------------------------------------------------------------
package rciaf_pkg;

    localparam int NUM_LANES = 4;
    localparam int PCT_W     = 15;
    localparam int THR_W     = 14;
    localparam int CNT_W     = 16;
    localparam int ALPHA_W   = 9;

    localparam logic [THR_W-1:0]   PCT_FULL   = 14'd12800;
    localparam logic [CNT_W-1:0]   CNT_MAX    = 16'hFFFF;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 9'd256;
    localparam logic [15:0]        DIV5_MUL   = 16'd52429;
    localparam int                 DIV5_SHIFT = 18;

    localparam logic [ALPHA_W-1:0] RST_LPF_WEIGHT        = 9'd38;
    localparam logic [CNT_W-1:0]   RST_ARM_HOLD_MS       = 16'd2000;
    localparam logic [CNT_W-1:0]   RST_SIGNAL_TIMEOUT_MS = 16'd500;
    localparam logic [THR_W-1:0]   RST_ARM_THR_LIMIT     = 14'd640;
    localparam logic [THR_W-1:0]   RST_ARM_YAW_THRESHOLD = 14'd11520;

    typedef logic signed [PCT_W-1:0] pct_t;

    typedef enum logic [1:0] {
        CMD_PACKET  = 2'd0,
        CMD_WAKE    = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_ARMED = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        REG_LPF_WEIGHT        = 3'd0,
        REG_ARM_HOLD_MS       = 3'd1,
        REG_SIGNAL_TIMEOUT_MS = 3'd2,
        REG_ARM_THR_LIMIT     = 3'd3,
        REG_ARM_YAW_THRESHOLD = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        LANE_THROTTLE = 1'b0,
        LANE_AXIS     = 1'b1
    } lane_kind_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] lpf_weight;
        logic [CNT_W-1:0]   arm_hold_ms;
        logic [CNT_W-1:0]   signal_timeout_ms;
        logic [THR_W-1:0]   arm_thr_limit;
        logic [THR_W-1:0]   arm_yaw_threshold;
    } cfg_t;

    typedef struct packed {
        logic [THR_W-1:0] throttle_pct;
        pct_t             roll_pct;
        pct_t             pitch_pct;
        pct_t             yaw_pct;
        logic             armed;
        phase_t           arm_phase;
        logic             signal_lost;
    } result_t;

    // exact floor(v / 5) for any 16-bit v
    function automatic logic [THR_W-1:0] div5(input logic [15:0] v);
        logic [31:0] prod;
        prod = {16'd0, v} * {16'd0, DIV5_MUL};
        return prod[DIV5_SHIFT +: THR_W];
    endfunction

endpackage

/* hw/rtl/rc_input_arming_failsafe_unit.sv */
// ----------------------------------------------------------------------------
// rc_input_arming_failsafe_unit
// RC stick scaling and filtering with stick arming and signal-loss failsafe.
//
//   channel | dir | contents
//   s_*     | in  | packet, wake, timeout or tick transaction
//   m_*     | out | command record on wake and timeout
//   cfg_*   | in  | register write: index, data
//
// Two stages: scale in four lanes, then filter and arming/failsafe update.
// One transaction per cycle unless stage one stalls; m_tvalid comes from the output register.
// m_tready low stalls only wake/timeout transactions waiting in stage one.
// Synchronous reset; no clearing pass follows.
// ----------------------------------------------------------------------------
module rc_input_arming_failsafe_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // throttle_us, roll_raw, pitch_raw, yaw_raw
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // throttle_pct, roll_pct, pitch_pct, yaw_pct,
                                   // armed, arm_phase, zero pad
    output logic [0:0]  m_tuser,   // signal_lost
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rciaf_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    st1_valid_reg;
    logic    st1_valid_next;
    cmd_t    st1_cmd_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t merge_result;
    logic    merge_has_result;
    logic    s_acc;
    logic    out_free;
    logic    commit;
    logic    commit_packet;
    pct_t    filt [NUM_LANES];

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                REG_LPF_WEIGHT:        cfg_next.lpf_weight        = cfg_data[ALPHA_W-1:0];
                REG_ARM_HOLD_MS:       cfg_next.arm_hold_ms       = cfg_data;
                REG_SIGNAL_TIMEOUT_MS: cfg_next.signal_timeout_ms = cfg_data;
                REG_ARM_THR_LIMIT:     cfg_next.arm_thr_limit     = cfg_data[THR_W-1:0];
                REG_ARM_YAW_THRESHOLD: cfg_next.arm_yaw_threshold = cfg_data[THR_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        out_free       = !out_valid_reg || m_tready;
        commit         = st1_valid_reg && (!merge_has_result || out_free);
        commit_packet  = commit && (st1_cmd_reg == CMD_PACKET);
        s_tready       = !st1_valid_reg || commit;
        s_acc          = s_tvalid && s_tready;
        st1_valid_next = s_acc ? 1'b1 : (commit ? 1'b0 : st1_valid_reg);
        if (commit && merge_has_result) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rciaf_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .kind      ((g == 0) ? LANE_THROTTLE : LANE_AXIS),
            .load      (s_acc),
            .raw       (s_tdata[16*g +: 16]),
            .commit    (commit_packet),
            .alpha     (cfg_reg.lpf_weight),
            .filt_next (filt[g])
        );
    end

    rciaf_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .commit     (commit),
        .cmd        (st1_cmd_reg),
        .filt       (filt),
        .cfg        (cfg_reg),
        .result     (merge_result),
        .has_result (merge_has_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lpf_weight        <= RST_LPF_WEIGHT;
            cfg_reg.arm_hold_ms       <= RST_ARM_HOLD_MS;
            cfg_reg.signal_timeout_ms <= RST_SIGNAL_TIMEOUT_MS;
            cfg_reg.arm_thr_limit     <= RST_ARM_THR_LIMIT;
            cfg_reg.arm_yaw_threshold <= RST_ARM_YAW_THRESHOLD;
            st1_valid_reg             <= 1'b0;
            out_valid_reg             <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            st1_valid_reg <= st1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            st1_cmd_reg <= cmd_t'(s_tuser);
        end
        if (commit && merge_has_result) begin
            out_reg <= merge_result;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_reg.arm_phase, out_reg.armed, out_reg.yaw_pct,
                        out_reg.pitch_pct, out_reg.roll_pct, out_reg.throttle_pct};
    assign m_tuser   = out_reg.signal_lost;

    a_st1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !commit |=> st1_valid_reg && $stable(st1_cmd_reg))
        else $error("stage one transaction lost while stalled");

    a_lost_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[58:0] == '0) && (m_tdata[61:60] == PH_IDLE))
        else $error("failsafe record not zeroed and disarmed");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:0] <= PCT_FULL) && (m_tdata[59] == (m_tdata[61:60] == PH_ARMED)))
        else $error("record throttle out of range or armed flag mismatch");

endmodule

/* hw/rtl/rciaf_lane.sv */
// ----------------------------------------------------------------------------
// rciaf_lane
// One channel: scale raw stick value to 1/128 percent, then low-pass filter.
// ----------------------------------------------------------------------------
module rciaf_lane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rciaf_pkg::lane_kind_t kind,
    input  logic                 load,
    input  logic [15:0]          raw,
    input  logic                 commit,
    input  logic [8:0]           alpha,
    output rciaf_pkg::pct_t      filt_next
);
    import rciaf_pkg::*;

    logic [15:0]        thr_off;
    logic signed [16:0] raw_x;
    logic [16:0]        mag;
    logic               neg;
    logic               sat;
    logic               zero;
    logic [15:0]        dividend;
    logic [THR_W-1:0]   quo;
    logic [THR_W-1:0]   mag_out;
    pct_t               scaled_next;
    pct_t               scaled_reg;
    pct_t               filt_reg;

    logic [ALPHA_W-1:0] a_eff;
    logic [ALPHA_W-1:0] w_old;
    logic signed [25:0] old_x;
    logic signed [25:0] new_x;
    logic signed [25:0] wo_x;
    logic signed [25:0] wn_x;
    logic signed [25:0] acc;
    logic [25:0]        acc_mag;
    logic [25:0]        rnd;
    logic [PCT_W-1:0]   q15;

    always_comb begin
        thr_off  = raw - 16'd1000;
        raw_x    = 17'($signed(raw));
        mag      = '0;
        neg      = 1'b0;
        sat      = 1'b0;
        zero     = 1'b0;
        dividend = '0;
        case (kind)
            LANE_THROTTLE: begin
                if (raw <= 16'd1000) begin
                    zero = 1'b1;
                end else if (raw >= 16'd2000) begin
                    sat = 1'b1;
                end else begin
                    dividend = {thr_off[9:0], 6'd0} + 16'd2;
                end
            end
            LANE_AXIS: begin
                neg = raw[15];
                mag = raw[15] ? 17'(-raw_x) : 17'(raw_x);
                if (mag >= 17'd500) begin
                    sat = 1'b1;
                end else begin
                    dividend = {mag[8:0], 7'd0} + 16'd2;
                end
            end
            default: begin
                zero = 1'b1;
            end
        endcase
        quo     = div5(dividend);
        mag_out = zero ? '0 : (sat ? PCT_FULL : quo);
        scaled_next = neg ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
    end

    always_comb begin
        a_eff   = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
        w_old   = ALPHA_ONE - a_eff;
        old_x   = 26'(filt_reg);
        new_x   = 26'(scaled_reg);
        wo_x    = 26'($signed({1'b0, w_old}));
        wn_x    = 26'($signed({1'b0, a_eff}));
        acc     = old_x * wo_x + new_x * wn_x;
        acc_mag = acc[25] ? 26'(-acc) : 26'(acc);
        rnd     = acc_mag + 26'd128;
        q15     = rnd[8 +: PCT_W];
        filt_next = acc[25] ? -$signed(q15) : $signed(q15);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            scaled_reg <= scaled_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
        end else if (commit) begin
            filt_reg <= filt_next;
        end
    end

endmodule

/* hw/rtl/rciaf_merge.sv */
// ----------------------------------------------------------------------------
// rciaf_merge
// Command record, arming state machine, tick counters and failsafe.
// ----------------------------------------------------------------------------
module rciaf_merge (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              commit,
    input  rciaf_pkg::cmd_t   cmd,
    input  rciaf_pkg::pct_t   filt [rciaf_pkg::NUM_LANES],
    input  rciaf_pkg::cfg_t   cfg,
    output rciaf_pkg::result_t result,
    output logic              has_result
);
    import rciaf_pkg::*;

    pct_t             rec_reg  [NUM_LANES];
    pct_t             rec_next [NUM_LANES];
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] hold_reg;
    logic [CNT_W-1:0] hold_next;
    logic [CNT_W-1:0] since_reg;
    logic [CNT_W-1:0] since_next;

    logic               low;
    logic               right;
    logic               left;
    logic               enter_wait;
    logic               timed_out;
    logic signed [15:0] yaw_x;
    logic signed [15:0] thr_x;

    always_comb begin
        low       = $unsigned(rec_reg[0]) < {1'b0, cfg.arm_thr_limit};
        yaw_x     = 16'(rec_reg[3]);
        thr_x     = $signed({2'b00, cfg.arm_yaw_threshold});
        right     = low && (yaw_x > thr_x);
        left      = low && (yaw_x < -thr_x);
        timed_out = since_reg >= cfg.signal_timeout_ms;
    end

    always_comb begin
        phase_next = phase_reg;
        enter_wait = 1'b0;
        if (commit) begin
            case (cmd)
                CMD_WAKE: begin
                    case (phase_reg)
                        PH_IDLE: begin
                            if (right) begin
                                phase_next = PH_WAIT;
                                enter_wait = 1'b1;
                            end
                        end
                        PH_WAIT: begin
                            if (!right) begin
                                phase_next = PH_IDLE;
                            end else if (hold_reg >= cfg.arm_hold_ms) begin
                                phase_next = PH_ARMED;
                            end
                        end
                        PH_ARMED: begin
                            if (left) begin
                                phase_next = PH_IDLE;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                CMD_TIMEOUT: begin
                    if (timed_out) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb begin
        rec_next   = rec_reg;
        hold_next  = hold_reg;
        since_next = since_reg;
        if (enter_wait) begin
            hold_next = '0;
        end
        if (commit) begin
            case (cmd)
                CMD_PACKET: begin
                    rec_next   = filt;
                    since_next = '0;
                end
                CMD_TICK: begin
                    if (since_reg != CNT_MAX) begin
                        since_next = since_reg + 16'd1;
                    end
                    if (hold_reg != CNT_MAX) begin
                        hold_next = hold_reg + 16'd1;
                    end
                end
                CMD_TIMEOUT: begin
                    if (timed_out) begin
                        for (int i = 0; i < NUM_LANES; i++) begin
                            rec_next[i] = '0;
                        end
                    end
                end
                default: begin
                    rec_next = rec_reg;
                end
            endcase
        end
    end

    always_comb begin
        result.throttle_pct = rec_next[0][THR_W-1:0];
        result.roll_pct     = rec_next[1];
        result.pitch_pct    = rec_next[2];
        result.yaw_pct      = rec_next[3];
        result.armed        = (phase_next == PH_ARMED);
        result.arm_phase    = phase_next;
        result.signal_lost  = (cmd == CMD_TIMEOUT) && timed_out;
        has_result          = (cmd == CMD_WAKE) || (cmd == CMD_TIMEOUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            hold_reg  <= '0;
            since_reg <= '0;
            for (int i = 0; i < NUM_LANES; i++) begin
                rec_reg[i] <= '0;
            end
        end else begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            since_reg <= since_next;
            rec_reg   <= rec_next;
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RC stick arming and failsafe unit.
//
// Drives packets, wake events, receive timeouts and millisecond ticks on the
// input stream and keeps its own copy of the scaling, filter, arming and
// failsafe state. Each wake or timeout transaction queues the record it must
// produce, and every output transaction is checked field by field against
// the oldest queued record. A short table of directed transactions goes
// first, then randomized stick gestures, flight traffic and noise under
// several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import rciaf_pkg::*;

    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 65;
    localparam int NUM_PHASES      = 7;
    localparam int FULL_SCALE      = PCT_FULL;

    typedef struct packed {
        bit          is_reg;
        cfg_idx_t    reg_idx;
        logic [15:0] reg_val;
        cmd_t        cmd;
        logic [15:0] thr;
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        bit          typed;
        result_t     fixed;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // stick state mirror
    int                 filt_mem [4];
    int                 cmd_rec [4];
    phase_t             stick_phase;
    int                 hold_ms;
    int                 quiet_ms;
    logic [ALPHA_W-1:0] alpha_q;
    logic [CNT_W-1:0]   hold_req_ms;
    logic [CNT_W-1:0]   timeout_ms;
    logic [THR_W-1:0]   thr_max_q;
    logic [THR_W-1:0]   yaw_thr_q;

    result_t   expected_records [$];
    stim_row_t plan [$];

    result_t got_rec;
    result_t want_rec;
    string   diff;

    int  errors;
    int  items_sent;
    int  records_checked;
    int  armed_seen;
    int  lost_seen;
    int  regs_written;
    int  hold_offs;
    int  quiet_cycles;
    bit  no_gaps;
    bit  hold_off_req;
    bit  hold_done;
    int  phase_start;

    rc_input_arming_failsafe_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int div_nearest(int num, int den);
        int mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic int sat_pct(int v, int lo);
        if (v > FULL_SCALE) return FULL_SCALE;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic int scale_stick(logic signed [15:0] raw);
        int r;
        r = raw;
        return sat_pct(div_nearest(r * 128, 5), -FULL_SCALE);
    endfunction

    function automatic int scale_pulse(logic [15:0] us);
        int x;
        x = us;
        x = x - 1000;
        if (x <= 0) return 0;
        if (x >= 1000) return FULL_SCALE;
        return div_nearest(x * 128, 10);
    endfunction

    function automatic int smooth(int old, int fresh);
        int a;
        a = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
        return div_nearest(old * (256 - a) + fresh * a, 256);
    endfunction

    function automatic result_t make_record(int thr, int roll, int pitch, int yaw,
                                            phase_t ph, logic lost);
        result_t r;
        r.throttle_pct = thr[THR_W-1:0];
        r.roll_pct     = roll[PCT_W-1:0];
        r.pitch_pct    = pitch[PCT_W-1:0];
        r.yaw_pct      = yaw[PCT_W-1:0];
        r.armed        = (ph == PH_ARMED);
        r.arm_phase    = ph;
        r.signal_lost  = lost;
        return r;
    endfunction

    // advance the stick state by one transaction; return 1 when a record is due
    function automatic bit step_model(cmd_t c, logic [15:0] thr, logic [15:0] roll,
                                      logic [15:0] pitch, logic [15:0] yaw,
                                      output result_t rec);
        int fresh [4];
        int thr_lim;
        int yaw_lim;
        int hold_lim;
        int quiet_lim;
        int i;
        bit low;
        bit right;
        bit left;
        rec = '0;
        case (c)
            CMD_PACKET: begin
                fresh[0] = scale_pulse(thr);
                fresh[1] = scale_stick(roll);
                fresh[2] = scale_stick(pitch);
                fresh[3] = scale_stick(yaw);
                for (i = 0; i < 4; i++) begin
                    filt_mem[i] = smooth(filt_mem[i], fresh[i]);
                    cmd_rec[i]  = filt_mem[i];
                end
                quiet_ms = 0;
                return 1'b0;
            end
            CMD_TICK: begin
                if (quiet_ms < 65535) quiet_ms++;
                if (hold_ms < 65535) hold_ms++;
                return 1'b0;
            end
            CMD_WAKE: begin
                thr_lim  = thr_max_q;
                yaw_lim  = yaw_thr_q;
                hold_lim = hold_req_ms;
                low   = cmd_rec[0] < thr_lim;
                right = low && (cmd_rec[3] > yaw_lim);
                left  = low && (cmd_rec[3] < -yaw_lim);
                case (stick_phase)
                    PH_IDLE: begin
                        if (right) begin
                            stick_phase = PH_WAIT;
                            hold_ms     = 0;
                        end
                    end
                    PH_WAIT: begin
                        if (!right) stick_phase = PH_IDLE;
                        else if (hold_ms >= hold_lim) stick_phase = PH_ARMED;
                    end
                    PH_ARMED: begin
                        if (left) stick_phase = PH_IDLE;
                    end
                    default: stick_phase = PH_IDLE;
                endcase
                rec = make_record(cmd_rec[0], cmd_rec[1], cmd_rec[2], cmd_rec[3],
                                  stick_phase, 1'b0);
                return 1'b1;
            end
            default: begin
                quiet_lim = timeout_ms;
                if (quiet_ms >= quiet_lim) begin
                    stick_phase = PH_IDLE;
                    for (i = 0; i < 4; i++) cmd_rec[i] = 0;
                    rec = make_record(0, 0, 0, 0, stick_phase, 1'b1);
                end else begin
                    rec = make_record(cmd_rec[0], cmd_rec[1], cmd_rec[2], cmd_rec[3],
                                      stick_phase, 1'b0);
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic logic [15:0] word();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] stick_nominal();
        logic [15:0] v;
        v = 16'($urandom_range(0, 1100));
        return v - 16'd550;
    endfunction

    function automatic void add_item(cmd_t c, int thr, int roll, int pitch, int yaw,
                                     bit typed, result_t fixed);
        stim_row_t row;
        row         = '0;
        row.cmd     = c;
        row.thr     = thr[15:0];
        row.roll    = roll[15:0];
        row.pitch   = pitch[15:0];
        row.yaw     = yaw[15:0];
        row.typed   = typed;
        row.fixed   = fixed;
        plan.push_back(row);
    endfunction

    function automatic void add_reg(cfg_idx_t idx, int val);
        stim_row_t row;
        row         = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val[15:0];
        plan.push_back(row);
    endfunction

    task automatic flag_error(string msg);
        errors++;
        if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic idle_input(int n);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic send_item(cmd_t c, logic [15:0] thr, logic [15:0] roll,
                             logic [15:0] pitch, logic [15:0] yaw,
                             bit typed, result_t fixed);
        result_t rec;
        bit      due;
        if (!no_gaps && $urandom_range(0, 99) < 10) idle_input($urandom_range(1, 4));
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {yaw, pitch, roll, thr};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        due = step_model(c, thr, roll, pitch, yaw, rec);
        if (due) expected_records.push_back(typed ? fixed : rec);
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_LPF_WEIGHT:        alpha_q     = val[ALPHA_W-1:0];
            REG_ARM_HOLD_MS:       hold_req_ms = val[CNT_W-1:0];
            REG_SIGNAL_TIMEOUT_MS: timeout_ms  = val[CNT_W-1:0];
            REG_ARM_THR_LIMIT:     thr_max_q   = val[THR_W-1:0];
            REG_ARM_YAW_THRESHOLD: yaw_thr_q   = val[THR_W-1:0];
            default: ;
        endcase
        regs_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(int alpha, int hold, int tmo, int thr_max, int yaw_thr);
        wait_drain();
        write_reg(REG_LPF_WEIGHT, alpha[15:0]);
        write_reg(REG_ARM_HOLD_MS, hold[15:0]);
        write_reg(REG_SIGNAL_TIMEOUT_MS, tmo[15:0]);
        write_reg(REG_ARM_THR_LIMIT, thr_max[15:0]);
        write_reg(REG_ARM_YAW_THRESHOLD, yaw_thr[15:0]);
    endtask

    task automatic run_episode();
        int          kind;
        int          len;
        bit          right;
        logic [15:0] yaw_mag;
        kind  = $urandom_range(0, 9);
        len   = $urandom_range(4, 20);
        right = ($urandom_range(0, 3) != 0);
        case (kind)
            0, 1, 2, 3, 4: begin
                // hold an arm or disarm gesture, polling with wakes
                repeat (len) begin
                    yaw_mag = 16'($urandom_range(470, 560));
                    send_item(CMD_PACKET, 16'($urandom_range(960, 1045)), stick_nominal(),
                              stick_nominal(), right ? yaw_mag : -yaw_mag, 1'b0, '0);
                    if ($urandom_range(0, 1))
                        send_item(CMD_WAKE, word(), word(), word(), word(), 1'b0, '0);
                    repeat ($urandom_range(0, 3))
                        send_item(CMD_TICK, word(), word(), word(), word(), 1'b0, '0);
                end
                repeat ($urandom_range(1, 3)) begin
                    repeat ($urandom_range(0, 4))
                        send_item(CMD_TICK, word(), word(), word(), word(), 1'b0, '0);
                    send_item(CMD_WAKE, word(), word(), word(), word(), 1'b0, '0);
                end
            end
            5, 6: begin
                repeat (len) begin
                    send_item(CMD_PACKET, 16'($urandom_range(950, 2050)), stick_nominal(),
                              stick_nominal(), stick_nominal(), 1'b0, '0);
                    if ($urandom_range(0, 3) == 0)
                        send_item(CMD_WAKE, word(), word(), word(), word(), 1'b0, '0);
                end
            end
            7: begin
                repeat (len)
                    send_item(cmd_t'($urandom_range(0, 3)), word(), word(), word(), word(),
                              1'b0, '0);
            end
            8: begin
                repeat ($urandom_range(0, 40))
                    send_item(CMD_TICK, word(), word(), word(), word(), 1'b0, '0);
                send_item(CMD_TIMEOUT, word(), word(), word(), word(), 1'b0, '0);
                send_item(CMD_WAKE, word(), word(), word(), word(), 1'b0, '0);
            end
            default: begin
                repeat (len)
                    send_item(cmd_t'($urandom_range(1, 3)), word(), word(), word(), word(),
                              1'b0, '0);
            end
        endcase
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_offs++;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= no_gaps || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_rec.throttle_pct = m_tdata[13:0];
            got_rec.roll_pct     = m_tdata[28:14];
            got_rec.pitch_pct    = m_tdata[43:29];
            got_rec.yaw_pct      = m_tdata[58:44];
            got_rec.armed        = m_tdata[59];
            got_rec.arm_phase    = phase_t'(m_tdata[61:60]);
            got_rec.signal_lost  = m_tuser[0];
            records_checked++;
            if (got_rec.armed === 1'b1) armed_seen++;
            if (got_rec.signal_lost === 1'b1) lost_seen++;
            if (expected_records.size() == 0) begin
                flag_error("output record with none expected");
            end else begin
                want_rec = expected_records.pop_front();
                diff = "";
                if (got_rec.throttle_pct !== want_rec.throttle_pct) diff = {diff, " throttle"};
                if (got_rec.roll_pct !== want_rec.roll_pct) diff = {diff, " roll"};
                if (got_rec.pitch_pct !== want_rec.pitch_pct) diff = {diff, " pitch"};
                if (got_rec.yaw_pct !== want_rec.yaw_pct) diff = {diff, " yaw"};
                if (got_rec.armed !== want_rec.armed) diff = {diff, " armed"};
                if (got_rec.arm_phase !== want_rec.arm_phase) diff = {diff, " arm_phase"};
                if (got_rec.signal_lost !== want_rec.signal_lost) diff = {diff, " signal_lost"};
                if (diff != "") begin
                    flag_error($sformatf({"record %0d differs in%s: expected ",
                        "thr=%0d roll=%0d pitch=%0d yaw=%0d armed=%0d phase=%0d lost=%0d, ",
                        "got thr=%0d roll=%0d pitch=%0d yaw=%0d armed=%0d phase=%0d lost=%0d"},
                        records_checked, diff,
                        want_rec.throttle_pct, want_rec.roll_pct, want_rec.pitch_pct,
                        want_rec.yaw_pct, want_rec.armed, want_rec.arm_phase,
                        want_rec.signal_lost,
                        got_rec.throttle_pct, got_rec.roll_pct, got_rec.pitch_pct,
                        got_rec.yaw_pct, got_rec.armed, got_rec.arm_phase,
                        got_rec.signal_lost));
                end
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d records pending",
                         quiet_cycles, expected_records.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_PACKET;
        cfg_valid    = 1'b0;
        cfg_index    = REG_LPF_WEIGHT;
        cfg_data     = '0;
        errors       = 0;
        items_sent   = 0;
        records_checked = 0;
        armed_seen   = 0;
        lost_seen    = 0;
        regs_written = 0;
        hold_offs    = 0;
        no_gaps      = 1'b0;
        hold_off_req = 1'b0;
        hold_done    = 1'b0;

        for (int i = 0; i < 4; i++) begin
            filt_mem[i] = 0;
            cmd_rec[i]  = 0;
        end
        stick_phase = PH_IDLE;
        hold_ms     = 0;
        quiet_ms    = 0;
        alpha_q     = RST_LPF_WEIGHT;
        hold_req_ms = RST_ARM_HOLD_MS;
        timeout_ms  = RST_SIGNAL_TIMEOUT_MS;
        thr_max_q   = RST_ARM_THR_LIMIT;
        yaw_thr_q   = RST_ARM_YAW_THRESHOLD;

        // reset record, timeout short of the limit
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b1, make_record(0, 0, 0, 0, PH_IDLE, 1'b0));
        add_item(CMD_TIMEOUT, 0, 0, 0, 0, 1'b1, make_record(0, 0, 0, 0, PH_IDLE, 1'b0));
        add_reg(REG_LPF_WEIGHT, 256);
        add_reg(REG_ARM_HOLD_MS, 0);
        add_reg(REG_SIGNAL_TIMEOUT_MS, 3);
        // field extremes pass straight through at full weight
        add_item(CMD_PACKET, 65535, 32767, -32768, 0, 1'b0, '0);
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b1,
                 make_record(12800, 12800, -12800, 0, PH_IDLE, 1'b0));
        add_item(CMD_PACKET, 0, -32768, 32767, -500, 1'b0, '0);
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b1,
                 make_record(0, -12800, 12800, -12800, PH_IDLE, 1'b0));
        // arm with zero hold, stay armed at high throttle, disarm
        add_item(CMD_PACKET, 1000, 1, -1, 500, 1'b0, '0);
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b0, '0);
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b0, '0);
        add_item(CMD_PACKET, 1999, -7, 7, -500, 1'b0, '0);
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b0, '0);
        add_item(CMD_PACKET, 1004, 0, 0, -500, 1'b0, '0);
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b0, '0);
        // wait released when the gesture drops
        add_item(CMD_PACKET, 900, 0, 0, 500, 1'b0, '0);
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b0, '0);
        add_item(CMD_PACKET, 900, 0, 0, 0, 1'b0, '0);
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b0, '0);
        // re-arm, then lose the signal
        add_item(CMD_PACKET, 1000, 0, 0, 500, 1'b0, '0);
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b0, '0);
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b0, '0);
        repeat (3) add_item(CMD_TICK, 0, 0, 0, 0, 1'b0, '0);
        add_item(CMD_TIMEOUT, 0, 0, 0, 0, 1'b1, make_record(0, 0, 0, 0, PH_IDLE, 1'b1));
        // oversized weight acts as full weight
        add_reg(REG_LPF_WEIGHT, 511);
        add_item(CMD_PACKET, 1500, 250, -250, 100, 1'b0, '0);
        add_item(CMD_WAKE, 0, 0, 0, 0, 1'b0, '0);

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                wait_drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].cmd, plan[i].thr, plan[i].roll, plan[i].pitch,
                          plan[i].yaw, plan[i].typed, plan[i].fixed);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: apply_settings(38, 4, 25, 640, 11520);
                1: apply_settings(0, 0, 0, 0, 0);
                2: apply_settings(256, 0, 12, 12800, 12000);
                3: apply_settings(511, 8, 65535, 16383, 11000);
                4: apply_settings(word(), word(), word(), word(), word());
                5: apply_settings(RST_LPF_WEIGHT, RST_ARM_HOLD_MS, RST_SIGNAL_TIMEOUT_MS,
                                  RST_ARM_THR_LIMIT, RST_ARM_YAW_THRESHOLD);
                default: apply_settings($urandom_range(20, 256), $urandom_range(0, 10),
                                        $urandom_range(0, 30), $urandom_range(300, 1500),
                                        $urandom_range(9000, 12000));
            endcase
            no_gaps     = (ph == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if (ph == 0 && !hold_done && items_sent - phase_start >= 20) begin
                    hold_off_req = 1'b1;
                    hold_done    = 1'b1;
                end
                run_episode();
            end
        end
        no_gaps = 1'b0;

        wait_drain();
        if (expected_records.size() != 0) flag_error("records still expected at end of run");

        $display("summary: %0d input transactions, %0d records checked (%0d armed, %0d failsafe)",
                 items_sent, records_checked, armed_seen, lost_seen);
        $display("summary: %0d register writes over %0d settings, %0d long hold-off, %0d errors",
                 regs_written, NUM_PHASES + 1, hold_offs, errors);
        if (errors == 0 && expected_records.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
